// ===== hdl/dfs_topological_sort_macros.svh =====
// ----------------------------------------------------------------------------
// dfs_topological_sort_macros.svh
// Assertion helpers shared by the topological sort RTL.
// ----------------------------------------------------------------------------
`ifndef DFS_TOPOLOGICAL_SORT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_MACROS_SVH

// same-cycle implication, masked during reset
`define DTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define DTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// Types and codes shared by the depth-first topological sort block.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SORT  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_CYCLE = 2'd2;

  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GRAY  = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_CINIT,
    ST_ROOT,
    ST_ROOTW,
    ST_SCAN,
    ST_CHK,
    ST_POPW,
    ST_READ
  } dts_state_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } stack_ctl_t;

endpackage

// ===== hdl/dts_stack.sv =====
// ----------------------------------------------------------------------------
// dts_stack
// Walk stack storage: saved vertex and neighbor cursor per depth level.
// ----------------------------------------------------------------------------
module dts_stack #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  dts_pkg::stack_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0]   addr,
  input  logic [$clog2(DEPTH)-1:0]   wvert,
  input  logic [$clog2(DEPTH+1)-1:0] wcur,
  output logic [$clog2(DEPTH)-1:0]   rvert,
  output logic [$clog2(DEPTH+1)-1:0] rcur
);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [IW+CW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= {wvert, wcur};
    end
    if (ctl.rd) begin
      {rvert, rcur} <= mem[addr];
    end
  end
endmodule

// ===== hdl/dfs_topological_sort.sv =====
// ----------------------------------------------------------------------------
// dfs_topological_sort
// Adjacency-bitmap graph store with an iterative depth-first topological sort.
// Every transaction ends with a done strobe: bad add edge, add edge, read, clear
//   and sort, which scans one neighbor bit per cycle except while the color of a
//   set neighbor is read and checked; a cycle ends it early.
// Throughput: one transaction at a time; busy drops as the result is shown.
// Results come as a one-cycle done strobe; the receiver cannot stall.
// Reset: rst sweeps the adjacency memory to zero with busy
//   high; vertex_count writes are taken only while idle with start low.
// ----------------------------------------------------------------------------
`include "dfs_topological_sort_macros.svh"

module dfs_topological_sort #(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk,
  input  logic       rst,
  // command channel
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [6:0] from_vertex,
  input  logic [6:0] to_vertex,
  input  logic [5:0] position,
  // result channel
  output logic       done,
  output logic [1:0] status,
  output logic       sort_valid,
  output logic [6:0] sorted_vertex,
  // vertex_count register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);
  localparam int IW   = $clog2(MAX_VERTICES);       // vertex index
  localparam int CW   = $clog2(MAX_VERTICES + 1);   // count / cursor
  localparam int CMPW = (CW > 7) ? CW : 7;          // common compare width
  localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_VERTICES);
  localparam logic [CW-1:0]   MAX_C = CW'(MAX_VERTICES);
  localparam logic [IW-1:0]   LAST_ROW = IW'(MAX_VERTICES - 1);

  // control registers
  dts_pkg::dts_state_t state, state_next;
  logic [CW-1:0] ci, ci_next;          // sweep counter
  logic [CW-1:0] root, root_next;
  logic [CW-1:0] sp, sp_next;          // depth, top kept in registers
  logic [IW-1:0] top_u, top_u_next;
  logic [CW-1:0] top_v, top_v_next;    // neighbor cursor of the top
  logic [CW-1:0] fill, fill_next;
  logic          list_valid, list_valid_next;
  logic [6:0]    vc, vc_next;
  logic          clr_reply, clr_reply_next;
  logic          rd_ok, rd_ok_next;
  logic [IW-1:0] edge_u, edge_u_next, edge_v, edge_v_next;
  logic          done_next;
  logic [1:0]    status_next;
  logic [6:0]    vert_next;

  // effective vertex count n = min(vertex_count, MAX_VERTICES)
  logic [CMPW-1:0] n_w;
  logic [CW-1:0]   n;
  assign n_w = (CMPW'(vc) > MAX_W) ? MAX_W : CMPW'(vc);
  assign n   = n_w[CW-1:0];

  logic [CMPW-1:0] f_w, t_w, p_w, f_m1, t_m1, srt_p1;
  assign f_w  = CMPW'(from_vertex);
  assign t_w  = CMPW'(to_vertex);
  assign p_w  = CMPW'(position);
  assign f_m1 = f_w - CMPW'(1);
  assign t_m1 = t_w - CMPW'(1);

  // adjacency memory: one row of MAX_VERTICES bits per source vertex
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic                    adj_we, adj_re;
  logic [IW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_q;

  // vertex colors
  logic [1:0]    col_mem [MAX_VERTICES];
  logic          col_we, col_re;
  logic [IW-1:0] col_waddr, col_raddr;
  logic [1:0]    col_wdata, col_q;

  // sorted list, filled from the end
  logic [IW-1:0] srt_mem [MAX_VERTICES];
  logic          srt_we, srt_re;
  logic [IW-1:0] srt_waddr, srt_raddr, srt_q;

  // walk stack
  dts_pkg::stack_ctl_t stk_ctl;
  logic [IW-1:0]       stk_addr, stk_rvert;
  logic [CW-1:0]       stk_rcur, stk_wcur;

  assign srt_p1 = CMPW'(srt_q) + CMPW'(1);

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    if (adj_re) begin
      adj_q <= adj_mem[adj_raddr];
    end
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    if (col_re) begin
      col_q <= col_mem[col_raddr];
    end
    if (srt_we) begin
      srt_mem[srt_waddr] <= top_u;
    end
    if (srt_re) begin
      srt_q <= srt_mem[srt_raddr];
    end
  end

  dts_stack #(
    .DEPTH (MAX_VERTICES)
  ) u_stack (
    .clk   (clk),
    .ctl   (stk_ctl),
    .addr  (stk_addr),
    .wvert (top_u),
    .wcur  (stk_wcur),
    .rvert (stk_rvert),
    .rcur  (stk_rcur)
  );

  assign busy      = (state != dts_pkg::ST_IDLE);
  // a register write lands between transactions, never beside a new one
  assign cfg_ready = (state == dts_pkg::ST_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dts_pkg::ST_CLEAR;
      ci         <= '0;
      root       <= '0;
      sp         <= '0;
      top_v      <= '0;
      fill       <= '0;
      list_valid <= 1'b0;
      vc         <= '0;
      clr_reply  <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      ci         <= ci_next;
      root       <= root_next;
      sp         <= sp_next;
      top_v      <= top_v_next;
      fill       <= fill_next;
      list_valid <= list_valid_next;
      vc         <= vc_next;
      clr_reply  <= clr_reply_next;
      done       <= done_next;
    end
    // payload, no reset needed
    top_u         <= top_u_next;
    rd_ok         <= rd_ok_next;
    edge_u        <= edge_u_next;
    edge_v        <= edge_v_next;
    status        <= status_next;
    sort_valid    <= list_valid_next;
    sorted_vertex <= vert_next;
  end

  always_comb begin
    state_next      = state;
    ci_next         = ci;
    root_next       = root;
    sp_next         = sp;
    top_u_next      = top_u;
    top_v_next      = top_v;
    fill_next       = fill;
    list_valid_next = list_valid;
    vc_next         = vc;
    clr_reply_next  = clr_reply;
    rd_ok_next      = rd_ok;
    edge_u_next     = edge_u;
    edge_v_next     = edge_v;
    done_next       = 1'b0;
    status_next     = dts_pkg::STATUS_OK;
    vert_next       = '0;
    adj_we          = 1'b0;
    adj_re          = 1'b0;
    adj_waddr       = edge_u;
    adj_raddr       = top_u;
    adj_wdata       = '0;
    col_we          = 1'b0;
    col_re          = 1'b0;
    col_waddr       = top_u;
    col_raddr       = top_v[IW-1:0];
    col_wdata       = dts_pkg::COLOR_WHITE;
    srt_we          = 1'b0;
    srt_re          = 1'b0;
    srt_waddr       = fill[IW-1:0];
    srt_raddr       = p_w[IW-1:0];
    stk_ctl         = '0;
    stk_addr        = '0;
    stk_wcur        = top_v + CW'(1);

    case (state)
      // zero all adjacency rows, after reset or for a clear transaction
      dts_pkg::ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = ci[IW-1:0];
        adj_wdata = '0;
        ci_next   = ci + CW'(1);
        if (ci[IW-1:0] == LAST_ROW) begin
          state_next     = dts_pkg::ST_IDLE;
          done_next      = clr_reply;
          clr_reply_next = 1'b0;
        end
      end

      dts_pkg::ST_IDLE: begin
        if (start) begin
          case (opcode)
            dts_pkg::OP_CLEAR: begin
              ci_next         = '0;
              clr_reply_next  = 1'b1;
              fill_next       = '0;
              list_valid_next = 1'b0;
              state_next      = dts_pkg::ST_CLEAR;
            end
            dts_pkg::OP_ADD: begin
              if (f_w == '0 || f_w > n_w || t_w == '0 || t_w > n_w) begin
                done_next   = 1'b1;
                status_next = dts_pkg::STATUS_BAD;
              end else begin
                adj_re      = 1'b1;
                adj_raddr   = f_m1[IW-1:0];
                edge_u_next = f_m1[IW-1:0];
                edge_v_next = t_m1[IW-1:0];
                state_next  = dts_pkg::ST_ADD;
              end
            end
            dts_pkg::OP_SORT: begin
              fill_next  = n;
              ci_next    = '0;
              root_next  = '0;
              state_next = dts_pkg::ST_CINIT;
            end
            default: begin
              rd_ok_next = list_valid && (p_w < n_w);
              srt_re     = 1'b1;
              state_next = dts_pkg::ST_READ;
            end
          endcase
        end
      end

      // row read-modify-write
      dts_pkg::ST_ADD: begin
        adj_we          = 1'b1;
        adj_wdata       = adj_q | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << edge_v);
        list_valid_next = 1'b0;
        done_next       = 1'b1;
        state_next      = dts_pkg::ST_IDLE;
      end

      // paint vertices 0..n-1 white
      dts_pkg::ST_CINIT: begin
        if (ci == n) begin
          state_next = dts_pkg::ST_ROOT;
        end else begin
          col_we    = 1'b1;
          col_waddr = ci[IW-1:0];
          col_wdata = dts_pkg::COLOR_WHITE;
          ci_next   = ci + CW'(1);
        end
      end

      dts_pkg::ST_ROOT: begin
        if (root == n) begin
          list_valid_next = 1'b1;
          done_next       = 1'b1;
          state_next      = dts_pkg::ST_IDLE;
        end else begin
          col_re     = 1'b1;
          col_raddr  = root[IW-1:0];
          state_next = dts_pkg::ST_ROOTW;
        end
      end

      dts_pkg::ST_ROOTW: begin
        if (col_q != dts_pkg::COLOR_WHITE) begin
          root_next  = root + CW'(1);
          state_next = dts_pkg::ST_ROOT;
        end else begin
          col_we     = 1'b1;
          col_waddr  = root[IW-1:0];
          col_wdata  = dts_pkg::COLOR_GRAY;
          top_u_next = root[IW-1:0];
          top_v_next = '0;
          sp_next    = CW'(1);
          adj_re     = 1'b1;
          adj_raddr  = root[IW-1:0];
          state_next = dts_pkg::ST_SCAN;
        end
      end

      // one neighbor bit per cycle until a set bit sends the walk to the color check; adj_q holds the top vertex's row
      dts_pkg::ST_SCAN: begin
        if (top_v == n) begin
          // top finishes: emit it and pop
          fill_next = (fill != '0) ? fill - CW'(1) : fill;
          srt_we    = 1'b1;
          srt_waddr = fill_next[IW-1:0];
          col_we    = 1'b1;
          col_waddr = top_u;
          col_wdata = dts_pkg::COLOR_BLACK;
          sp_next   = sp - CW'(1);
          if (sp == CW'(1)) begin
            root_next  = root + CW'(1);
            state_next = dts_pkg::ST_ROOT;
          end else begin
            stk_ctl.rd = 1'b1;
            stk_addr   = sp_next[IW-1:0] - IW'(1);
            state_next = dts_pkg::ST_POPW;
          end
        end else if (adj_q[top_v[IW-1:0]]) begin
          col_re     = 1'b1;
          state_next = dts_pkg::ST_CHK;
        end else begin
          top_v_next = top_v + CW'(1);
        end
      end

      dts_pkg::ST_CHK: begin
        if (col_q == dts_pkg::COLOR_GRAY) begin
          list_valid_next = 1'b0;
          done_next       = 1'b1;
          status_next     = dts_pkg::STATUS_CYCLE;
          state_next      = dts_pkg::ST_IDLE;
        end else if (col_q == dts_pkg::COLOR_WHITE && sp < MAX_C) begin
          // save the top with its cursor past this neighbor, descend
          stk_ctl.wr = 1'b1;
          stk_addr   = sp[IW-1:0] - IW'(1);
          col_we     = 1'b1;
          col_waddr  = top_v[IW-1:0];
          col_wdata  = dts_pkg::COLOR_GRAY;
          top_u_next = top_v[IW-1:0];
          top_v_next = '0;
          sp_next    = sp + CW'(1);
          adj_re     = 1'b1;
          adj_raddr  = top_v[IW-1:0];
          state_next = dts_pkg::ST_SCAN;
        end else begin
          top_v_next = top_v + CW'(1);
          state_next = dts_pkg::ST_SCAN;
        end
      end

      dts_pkg::ST_POPW: begin
        top_u_next = stk_rvert;
        top_v_next = stk_rcur;
        adj_re     = 1'b1;
        adj_raddr  = stk_rvert;
        state_next = dts_pkg::ST_SCAN;
      end

      dts_pkg::ST_READ: begin
        vert_next  = rd_ok ? srt_p1[6:0] : 7'd0;
        done_next  = 1'b1;
        state_next = dts_pkg::ST_IDLE;
      end

      default: begin
        state_next = dts_pkg::ST_IDLE;
      end
    endcase

    // register write, accepted only while idle
    if (cfg_valid && cfg_ready) begin
      vc_next         = cfg_data;
      list_valid_next = 1'b0;
    end
  end

  // checks
  `DTS_ASSERT_IMPL(a_cycle_clears_valid, clk, rst, done && status == dts_pkg::STATUS_CYCLE, !sort_valid, "cycle result with sort_valid set")
  `DTS_ASSERT_IMPL(a_depth_bound, clk, rst, 1'b1, sp <= MAX_C, "walk depth beyond MAX_VERTICES")
  `DTS_ASSERT_NEXT(a_gray_reports, clk, rst, state == dts_pkg::ST_CHK && col_q == dts_pkg::COLOR_GRAY, done && status == dts_pkg::STATUS_CYCLE, "gray neighbor not reported as cycle")

endmodule
